// File: rtl/core/dcc_pkg.sv
// Package for the disc changer command state core.
// Holds the slot count, operation codes and play state codes.
// Depends on nothing.
`default_nettype none

package dcc_pkg;

  localparam int NUM_SLOTS = 6;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [3:0] OP_INSERT      = 4'd0;
  localparam logic [3:0] OP_REMOVE      = 4'd1;
  localparam logic [3:0] OP_SELECT_DISC = 4'd2;
  localparam logic [3:0] OP_SELECT_TRK  = 4'd3;
  localparam logic [3:0] OP_PLAY        = 4'd4;
  localparam logic [3:0] OP_PAUSE       = 4'd5;
  localparam logic [3:0] OP_STOP        = 4'd6;
  localparam logic [3:0] OP_NEXT_DISC   = 4'd7;
  localparam logic [3:0] OP_PREV_DISC   = 4'd8;
  localparam logic [3:0] OP_NEXT_TRK    = 4'd9;
  localparam logic [3:0] OP_PREV_TRK    = 4'd10;
  localparam logic [3:0] OP_QUERY       = 4'd11;

  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_PLAYING = 2'd1;
  localparam logic [1:0] MODE_PAUSED  = 2'd2;

endpackage

`default_nettype wire

// File: rtl/core/dcc_cmd_if.sv
// Command channel of the disc changer command state core.
// Carries valid, ready and one command word; depends on nothing.
`default_nettype none

interface dcc_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] operation;
  logic [7:0] disc_number;
  logic [7:0] track_count;
  logic [7:0] track_number;

  modport source (output valid, operation, disc_number, track_count, track_number,
                  input ready);
  modport sink (input valid, operation, disc_number, track_count, track_number,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/dcc_stat_if.sv
// Status channel of the disc changer command state core.
// Carries valid, ready and one status word; depends on nothing.
`default_nettype none

interface dcc_stat_if;
  logic       valid;
  logic       ready;
  logic [3:0] current_disc;
  logic [7:0] current_track;
  logic [1:0] play_state;
  logic       current_present;
  logic       queried_present;
  logic [7:0] queried_tracks;

  modport source (output valid, current_disc, current_track, play_state,
                  current_present, queried_present, queried_tracks,
                  input ready);
  modport sink (input valid, current_disc, current_track, play_state,
                current_present, queried_present, queried_tracks,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/disc_changer_command_state.sv
// Top level of the disc changer command state core.
// Depends on dcc_pkg, dcc_cmd_if and dcc_stat_if.
//
// Each command word returns one status word that shows the state after the command.
// An accepted command passes through the load, execute and query states to the status
// register, which is written once the previous status word has been taken. A next or
// previous disc command adds a seek state that visits the slots one by one in a circular
// search, up to NUM_SLOTS of them. All slot reads share one read port. A new command is
// accepted while the previous status word still waits to be taken.
`default_nettype none

module disc_changer_command_state_core (
  input  wire logic clk,
  input  wire logic rst,
  dcc_cmd_if.sink   cmd,
  dcc_stat_if.source status
);
  import dcc_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_EXEC, S_SEEK, S_QUERY, S_STATUS
  } state_t;

  state_t state;

  logic [NUM_SLOTS-1:0] slot_present;
  logic [7:0]           slot_tracks [NUM_SLOTS];
  logic [SLOT_W-1:0]    disc_now;
  logic [7:0]           track_now;
  logic [1:0]           mode_now;

  logic [3:0]        op;
  logic [7:0]        dn;
  logic [7:0]        tc;
  logic [7:0]        tn;
  logic              ld_present;
  logic [7:0]        ld_tracks;
  logic [SLOT_W-1:0] cand;
  logic [SLOT_W-1:0] seek_cnt;
  logic              seek_back;
  logic              q_present;
  logic [7:0]        q_tracks;
  logic              stat_valid;

  logic              dn_ok;
  logic [SLOT_W-1:0] dn_idx;
  logic [SLOT_W-1:0] rd_idx;
  logic              rd_ok;
  logic              rd_present;
  logic [7:0]        rd_tracks;

  function automatic logic [SLOT_W-1:0] step_slot(input logic [SLOT_W-1:0] p,
                                                  input logic back);
    logic [SLOT_W-1:0] r;
    if (back) begin
      r = (p == '0) ? SLOT_LAST : p - SLOT_W'(1);
    end else begin
      r = (p == SLOT_LAST) ? '0 : p + SLOT_W'(1);
    end
    return r;
  endfunction

  assign dn_ok  = dn < 8'(NUM_SLOTS);
  assign dn_idx = dn[SLOT_W-1:0];

  always_comb begin
    unique case (state)
      S_LOAD:  rd_idx = (op == OP_SELECT_DISC) ? dn_idx : disc_now;
      S_SEEK:  rd_idx = cand;
      S_QUERY: rd_idx = dn_idx;
      default: rd_idx = disc_now;
    endcase
  end

  assign rd_ok      = rd_idx <= SLOT_LAST;
  assign rd_present = rd_ok ? slot_present[rd_idx] : 1'b0;
  assign rd_tracks  = rd_ok ? slot_tracks[rd_idx] : 8'd0;

  assign cmd.ready    = (state == S_IDLE);
  assign status.valid = stat_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stat_valid   <= 1'b0;
      slot_present <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_tracks[i] <= 8'd0;
      end
      disc_now  <= '0;
      track_now <= 8'd1;
      mode_now  <= MODE_STOPPED;
    end else begin
      if (stat_valid && status.ready && state != S_STATUS) begin
        stat_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op    <= cmd.operation;
            dn    <= cmd.disc_number;
            tc    <= cmd.track_count;
            tn    <= cmd.track_number;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          ld_present <= rd_present;
          ld_tracks  <= rd_tracks;
          state      <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_QUERY;
          case (op)
            OP_INSERT: begin
              if (dn_ok) begin
                slot_present[dn_idx] <= 1'b1;
                slot_tracks[dn_idx]  <= tc;
              end
            end
            OP_REMOVE: begin
              if (dn_ok) begin
                slot_present[dn_idx] <= 1'b0;
                slot_tracks[dn_idx]  <= 8'd0;
                if (8'(disc_now) == dn) begin
                  mode_now  <= MODE_STOPPED;
                  track_now <= 8'd1;
                  disc_now  <= '0;
                end
              end
            end
            OP_SELECT_DISC: begin
              if (dn_ok && ld_present) begin
                disc_now  <= dn_idx;
                track_now <= 8'd1;
              end
            end
            OP_SELECT_TRK: begin
              if (tn != 8'd0 && tn <= ld_tracks) begin
                track_now <= tn;
              end
            end
            OP_PLAY: begin
              if (ld_present) begin
                mode_now <= MODE_PLAYING;
              end
            end
            OP_PAUSE: begin
              if (mode_now == MODE_PLAYING) begin
                mode_now <= MODE_PAUSED;
              end
            end
            OP_STOP: begin
              mode_now  <= MODE_STOPPED;
              track_now <= 8'd1;
            end
            OP_NEXT_DISC, OP_PREV_DISC: begin
              seek_back <= (op == OP_PREV_DISC);
              cand      <= step_slot(disc_now, op == OP_PREV_DISC);
              seek_cnt  <= '0;
              state     <= S_SEEK;
            end
            OP_NEXT_TRK: begin
              if (track_now < ld_tracks) begin
                track_now <= track_now + 8'd1;
              end
            end
            OP_PREV_TRK: begin
              if (track_now > 8'd1) begin
                track_now <= track_now - 8'd1;
              end
            end
            default: begin
            end
          endcase
        end
        S_SEEK: begin
          if (rd_present) begin
            disc_now  <= cand;
            track_now <= 8'd1;
            mode_now  <= MODE_PLAYING;
            state     <= S_QUERY;
          end else if (seek_cnt == SLOT_LAST) begin
            state <= S_QUERY;
          end else begin
            cand     <= step_slot(cand, seek_back);
            seek_cnt <= seek_cnt + SLOT_W'(1);
          end
        end
        S_QUERY: begin
          q_present <= dn_ok && rd_present;
          q_tracks  <= dn_ok ? rd_tracks : 8'd0;
          state     <= S_STATUS;
        end
        S_STATUS: begin
          if (!stat_valid || status.ready) begin
            status.current_disc    <= 4'(disc_now);
            status.current_track   <= track_now;
            status.play_state      <= mode_now;
            status.current_present <= rd_present;
            status.queried_present <= q_present;
            status.queried_tracks  <= q_tracks;
            stat_valid             <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_disc_in_range: assert property (@(posedge clk) disable iff (rst)
    disc_now <= SLOT_LAST)
    else $error("current disc beyond the last slot");

  a_track_nonzero: assert property (@(posedge clk) disable iff (rst)
    track_now != 8'd0)
    else $error("current track is zero");

  a_active_needs_disc: assert property (@(posedge clk) disable iff (rst)
    mode_now != MODE_STOPPED |-> slot_present[disc_now])
    else $error("playing or paused with an empty current slot");

  a_seek_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_SEEK |-> seek_cnt <= SLOT_LAST)
    else $error("disc search ran past all slots");

endmodule

`default_nettype wire
